// ----- rtl/lpl_pkg.sv -----
// shared types, constants and helpers of the look-ahead peak limiter
package lpl_pkg;

    localparam int SAMPLE_BITS       = 24;
    localparam int FRAC_BITS         = SAMPLE_BITS - 1;
    localparam int MAX_LOOKAHEAD_DEF = 128;
    localparam int CFG_DATA_BITS     = 24;

    localparam logic [SAMPLE_BITS-1:0] UNITY = SAMPLE_BITS'(1) << FRAC_BITS;

    localparam logic [23:0] THRESHOLD_RST = 24'd7476394;
    localparam logic [22:0] CEILING_RST   = 23'd8292218;
    localparam logic [22:0] RELEASE_RST   = 23'd8386930;
    localparam logic [7:0]  WINDOW_RST    = 8'd72;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_CEILING   = 2'd1,
        CFG_RELEASE   = 2'd2,
        CFG_WINDOW    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_cfg_reg                 index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [23:0] threshold;
        logic [22:0] ceiling;
        logic [22:0] release_coef;
        logic [7:0]  window;
    } t_cfg_regs;

    typedef struct packed {
        logic                           action;
        logic signed [SAMPLE_BITS-1:0]  sample_in;
        logic                           sample_invalid;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  sample_out;
        logic                           faulted;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DIV,
        ST_GMUL,
        ST_GAIN,
        ST_YMUL,
        ST_YOUT,
        ST_EMIT
    } t_state;

    function automatic logic [SAMPLE_BITS-1:0] mag(input logic signed [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] r;
        r = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
        return r;
    endfunction

endpackage

// ----- rtl/lpl_chan_if.sv -----
// valid/ready channel carrying one payload item per transfer
interface lpl_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/lpl_cfg_regs.sv -----
// configuration register file, written through its own channel
module lpl_cfg_regs import lpl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpl_chan_if.sink   i_cfg_ch,
    output t_cfg_regs  o_cfg
);

    t_cfg_regs r_cfg;
    t_cfg_regs n_cfg;

    assign i_cfg_ch.ready = 1'b1;
    assign o_cfg          = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_ch.valid) begin
            case (i_cfg_ch.payload.index)
                CFG_THRESHOLD: n_cfg.threshold    = i_cfg_ch.payload.data[23:0];
                CFG_CEILING:   n_cfg.ceiling      = i_cfg_ch.payload.data[22:0];
                CFG_RELEASE:   n_cfg.release_coef = i_cfg_ch.payload.data[22:0];
                CFG_WINDOW:    n_cfg.window       = i_cfg_ch.payload.data[7:0];
                default:       n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= THRESHOLD_RST;
            r_cfg.ceiling      <= CEILING_RST;
            r_cfg.release_coef <= RELEASE_RST;
            r_cfg.window       <= WINDOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- rtl/lpl_ring_mem.sv -----
// delay ring storage: one write port, one read port with registered data
module lpl_ring_mem import lpl_pkg::*; #(
    parameter int DEPTH = MAX_LOOKAHEAD_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic signed [SAMPLE_BITS-1:0] o_rdata
);

    logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ----- rtl/lpl_div.sv -----
// restoring divider for threshold * 2^23 / peak, one quotient bit per cycle
module lpl_div import lpl_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_dividend,
    input  logic [SAMPLE_BITS-1:0] i_divisor,
    output logic                   o_done,
    output logic [SAMPLE_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [SAMPLE_BITS:0]   r_rem;
    logic [SAMPLE_BITS-1:0] r_quo;
    logic [SAMPLE_BITS-1:0] r_dvs;

    logic [SAMPLE_BITS:0]   rem2;
    logic                   ge;
    logic [SAMPLE_BITS:0]   n_rem;

    // dividend < divisor on start, so remainder stays below the divisor
    always_comb begin
        rem2  = {r_rem[SAMPLE_BITS-1:0], 1'b0};
        ge    = rem2 >= {1'b0, r_dvs};
        n_rem = ge ? (rem2 - {1'b0, r_dvs}) : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_dividend};
            r_quo <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SAMPLE_BITS-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/lookahead_peak_limiter.sv -----
// look-ahead peak limiter top level: sequencer, ring scan, gain and output stage
// a sample is scanned against the ring through its single read port, then passes the
// write, gain and output states, and the serial divider when the peak is above threshold;
// one item at a time, the next sample accepted in the cycle after the previous one has
// reached the output register. fault results skip the scan and the gain arithmetic.
// reset and a clear item zero all MAX_LOOKAHEAD ring entries in one pass, no items taken
module lookahead_peak_limiter import lpl_pkg::*; #(
    parameter int MAX_LOOKAHEAD = MAX_LOOKAHEAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpl_chan_if.sink    i_in_ch,
    lpl_chan_if.source  o_out_ch,
    lpl_chan_if.sink    i_cfg_ch
);

    localparam int AW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
    localparam int CW = $clog2(MAX_LOOKAHEAD + 1);
    localparam int PW = 2 * SAMPLE_BITS;

    t_cfg_regs cfg;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]                 r_idx,     n_idx;
    logic                          r_rd_vld,  n_rd_vld;
    logic [AW-1:0]                 r_rd_tag,  n_rd_tag;
    logic                          r_rd_last, n_rd_last;
    logic [CW-1:0]                 r_len,     n_len;
    logic [AW-1:0]                 r_widx,    n_widx;
    logic [AW-1:0]                 r_wptr,    n_wptr;
    logic signed [SAMPLE_BITS-1:0] r_x,       n_x;
    logic signed [SAMPLE_BITS-1:0] r_delayed, n_delayed;
    logic [SAMPLE_BITS-1:0]        r_peak,    n_peak;
    logic [SAMPLE_BITS-1:0]        r_needed,  n_needed;
    logic [SAMPLE_BITS-1:0]        r_gain,    n_gain;
    logic                          r_fault,   n_fault;
    logic [PW-1:0]                 r_prod,    n_prod;
    t_out_item                     r_res,     n_res;
    logic                          r_out_vld, n_out_vld;
    t_out_item                     r_out,     n_out;

    logic                          in_fire;
    logic                          out_free;
    logic [CW-1:0]                 len_now;
    logic [AW-1:0]                 widx_now;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic signed [SAMPLE_BITS-1:0] mem_wdata;
    logic                          mem_re;
    logic signed [SAMPLE_BITS-1:0] mem_rdata;

    logic                          div_start;
    logic                          div_done;
    logic [SAMPLE_BITS-1:0]        div_quo;

    logic [SAMPLE_BITS-1:0]        mul_a;
    logic [SAMPLE_BITS-1:0]        mul_b;
    logic [SAMPLE_BITS-1:0]        scan_mag;
    logic [SAMPLE_BITS:0]          ymag;

    lpl_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_ch (i_cfg_ch),
        .o_cfg    (cfg)
    );

    lpl_ring_mem #(
        .DEPTH (MAX_LOOKAHEAD),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    lpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (cfg.threshold),
        .i_divisor  (r_peak),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign i_in_ch.ready    = (r_state == ST_IDLE);
    assign in_fire          = i_in_ch.valid && (r_state == ST_IDLE);
    assign out_free         = !r_out_vld || o_out_ch.ready;
    assign o_out_ch.valid   = r_out_vld;
    assign o_out_ch.payload = r_out;

    // window length in use, clamped to 1..MAX_LOOKAHEAD
    always_comb begin
        if (cfg.window == 8'd0) begin
            len_now = CW'(1);
        end else if (32'(cfg.window) > 32'(MAX_LOOKAHEAD)) begin
            len_now = CW'(MAX_LOOKAHEAD);
        end else begin
            len_now = CW'(cfg.window);
        end
        widx_now = (CW'(r_wptr) >= len_now) ? '0 : r_wptr;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_idx == CW'(MAX_LOOKAHEAD - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in_ch.payload.action) begin
                        n_state = ST_CLEAR;
                    end else if (r_fault || i_in_ch.payload.sample_invalid) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && r_rd_last) n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = (r_peak > cfg.threshold) ? ST_DIV : ST_GMUL;
            end
            ST_DIV: begin
                if (div_done) n_state = ST_GMUL;
            end
            ST_GMUL: begin
                n_state = (r_needed < r_gain) ? ST_YMUL : ST_GAIN;
            end
            ST_GAIN: n_state = ST_YMUL;
            ST_YMUL: n_state = ST_YOUT;
            ST_YOUT: n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_rd_tag  = r_rd_tag;
        n_rd_last = r_rd_last;
        n_len     = r_len;
        n_widx    = r_widx;
        n_wptr    = r_wptr;
        n_x       = r_x;
        n_delayed = r_delayed;
        n_peak    = r_peak;
        n_needed  = r_needed;
        n_gain    = r_gain;
        n_fault   = r_fault;
        n_prod    = r_prod;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_out_ch.ready;

        mem_we    = 1'b0;
        mem_waddr = r_widx;
        mem_wdata = r_x;
        mem_re    = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        scan_mag  = '0;
        ymag      = '0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[AW-1:0];
                mem_wdata = '0;
                n_idx     = (r_idx == CW'(MAX_LOOKAHEAD - 1)) ? '0 : r_idx + CW'(1);
            end
            ST_IDLE: begin
                n_idx  = '0;
                n_peak = '0;
                if (in_fire) begin
                    if (i_in_ch.payload.action) begin
                        n_wptr  = '0;
                        n_gain  = UNITY;
                        n_fault = 1'b0;
                    end else if (r_fault || i_in_ch.payload.sample_invalid) begin
                        n_fault          = 1'b1;
                        n_res.sample_out = '0;
                        n_res.faulted    = 1'b1;
                    end else begin
                        n_len  = len_now;
                        n_widx = widx_now;
                        n_x    = i_in_ch.payload.sample_in;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx < r_len) begin
                    mem_re    = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_tag  = r_idx[AW-1:0];
                    n_rd_last = (r_idx == r_len - CW'(1));
                    n_idx     = r_idx + CW'(1);
                end
                // the new sample stands in for the entry it replaces
                if (r_rd_vld) begin
                    if (r_rd_tag == r_widx) begin
                        scan_mag  = mag(r_x);
                        n_delayed = mem_rdata;
                    end else begin
                        scan_mag = mag(mem_rdata);
                    end
                    if (scan_mag > r_peak) n_peak = scan_mag;
                end
            end
            ST_WRITE: begin
                mem_we = 1'b1;
                n_wptr = (CW'(r_widx) + CW'(1) == r_len) ? '0 : r_widx + AW'(1);
                if (r_peak > cfg.threshold) begin
                    div_start = 1'b1;
                end else begin
                    n_needed = UNITY;
                end
            end
            ST_DIV: begin
                if (div_done) n_needed = div_quo;
            end
            ST_GMUL: begin
                if (r_needed < r_gain) begin
                    n_gain = r_needed;
                end else begin
                    mul_a  = r_needed - r_gain;
                    mul_b  = {1'b0, cfg.release_coef};
                    n_prod = PW'(mul_a) * PW'(mul_b);
                end
            end
            ST_GAIN: begin
                n_gain = r_needed - r_prod[FRAC_BITS +: SAMPLE_BITS];
            end
            ST_YMUL: begin
                mul_a  = mag(r_delayed);
                mul_b  = r_gain;
                n_prod = PW'(mul_a) * PW'(mul_b);
            end
            ST_YOUT: begin
                ymag = r_prod[FRAC_BITS +: (SAMPLE_BITS + 1)];
                if (ymag > (SAMPLE_BITS + 1)'(cfg.ceiling)) begin
                    ymag = (SAMPLE_BITS + 1)'(cfg.ceiling);
                end
                n_res.sample_out = r_delayed[SAMPLE_BITS-1] ? -ymag[SAMPLE_BITS-1:0]
                                                            : ymag[SAMPLE_BITS-1:0];
                n_res.faulted    = 1'b0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_idx = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_wptr    <= '0;
            r_gain    <= UNITY;
            r_fault   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_wptr    <= n_wptr;
            r_gain    <= n_gain;
            r_fault   <= n_fault;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_tag  <= n_rd_tag;
        r_rd_last <= n_rd_last;
        r_len     <= n_len;
        r_widx    <= n_widx;
        r_x       <= n_x;
        r_delayed <= n_delayed;
        r_peak    <= n_peak;
        r_needed  <= n_needed;
        r_prod    <= n_prod;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    a_clear_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in_ch.payload.action)
        |=> (r_state == ST_CLEAR && r_gain == UNITY && !r_fault && r_wptr == '0))
        else $error("clear item did not restore state");

    a_gain_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= UNITY)
        else $error("gain above unity");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !mem_we)
        else $error("ring written during scan");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.payload.faulted) |-> (o_out_ch.payload.sample_out == '0))
        else $error("faulted result carries nonzero sample");

    a_div_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its wait state");

endmodule

// ----- tb/lookahead_peak_limiter_checker.sv -----
// channel monitor with a fixed-point limiter predictor and an in-order result comparison
module lookahead_peak_limiter_checker import lpl_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  t_cfg_write i_cfg_write,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0] threshold_reg;
    logic [22:0] ceiling_reg;
    logic [22:0] release_reg;
    logic [7:0]  window_reg;

    logic signed [SAMPLE_BITS-1:0] ring [MAX_LOOKAHEAD_DEF];
    int unsigned                   write_pos;
    logic [SAMPLE_BITS-1:0]        gain;
    logic                          fault_latched;

    t_out_item limited_q [$];
    int        fail_count = 0;

    function automatic longint unsigned abs_sample(logic signed [SAMPLE_BITS-1:0] v);
        longint s;
        s = v;
        return (s < 0) ? -s : s;
    endfunction

    function automatic void flush_state();
        for (int i = 0; i < MAX_LOOKAHEAD_DEF; i++) begin
            ring[i] = '0;
        end
        write_pos     = 0;
        gain          = UNITY;
        fault_latched = 1'b0;
    endfunction

    function automatic void predict_limited(t_in_item item);
        int unsigned                   len;
        logic signed [SAMPLE_BITS-1:0] delayed;
        longint unsigned               thr, peak, m, needed, g, ymag;
        longint                        y;
        t_out_item                     res;
        if (item.action) begin
            flush_state();
            return;
        end
        if (fault_latched || item.sample_invalid) begin
            fault_latched  = 1'b1;
            res.sample_out = '0;
            res.faulted    = 1'b1;
            limited_q.push_back(res);
            return;
        end
        len = (window_reg == 0) ? 1 :
              ((window_reg > MAX_LOOKAHEAD_DEF) ? MAX_LOOKAHEAD_DEF : window_reg);
        // index left over from a longer window restarts at the front
        if (write_pos >= len) write_pos = 0;
        delayed         = ring[write_pos];
        ring[write_pos] = item.sample_in;
        write_pos       = (write_pos + 1) % len;

        peak = 0;
        for (int i = 0; i < len; i++) begin
            m = abs_sample(ring[i]);
            if (m > peak) peak = m;
        end

        thr = threshold_reg;
        if (peak > thr) needed = (thr << FRAC_BITS) / peak;
        else            needed = UNITY;

        // attack is instant, release approaches the needed gain with a truncated step
        g = gain;
        if (needed < g) g = needed;
        else            g = needed - (((needed - g) * release_reg) >> FRAC_BITS);
        gain = SAMPLE_BITS'(g);

        ymag = (abs_sample(delayed) * g) >> FRAC_BITS;
        if (ymag > ceiling_reg) ymag = ceiling_reg;
        y = (delayed < 0) ? -longint'(ymag) : longint'(ymag);

        res.sample_out = SAMPLE_BITS'(y);
        res.faulted    = 1'b0;
        limited_q.push_back(res);
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            threshold_reg = THRESHOLD_RST;
            ceiling_reg   = CEILING_RST;
            release_reg   = RELEASE_RST;
            window_reg    = WINDOW_RST;
            flush_state();
            limited_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_write.index)
                    CFG_THRESHOLD: threshold_reg = i_cfg_write.data;
                    CFG_CEILING:   ceiling_reg   = i_cfg_write.data[22:0];
                    CFG_RELEASE:   release_reg   = i_cfg_write.data[22:0];
                    CFG_WINDOW:    window_reg    = i_cfg_write.data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_limited(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (limited_q.size() == 0) begin
                    $error("unexpected result transfer: sample_out %0d faulted %0b",
                           $signed(i_out_item.sample_out), i_out_item.faulted);
                    fail_count++;
                end else begin
                    want = limited_q.pop_front();
                    if (i_out_item.sample_out !== want.sample_out) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               $signed(want.sample_out), $signed(i_out_item.sample_out));
                        fail_count++;
                    end
                    if (i_out_item.faulted !== want.faulted) begin
                        $error("faulted mismatch: expected %0b, actual %0b",
                               want.faulted, i_out_item.faulted);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= limited_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- tb/lookahead_peak_limiter_test.sv -----
// top of the limiter testbench: clock, reset, stimulus, receiver throttling and verdict
module lookahead_peak_limiter_test import lpl_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_SAMPLE    = 1'b0;
    localparam logic ACT_CLEAR     = 1'b1;
    localparam int   STALL_LIMIT   = 5000;
    localparam int   SETTLE_CYCLES = 320;
    localparam int   LONG_HOLD     = 600;
    localparam int   PHASES        = 12;

    logic i_clk;
    logic i_rst_n;

    lpl_chan_if #(.t_payload(t_in_item))   in_ch  ();
    lpl_chan_if #(.t_payload(t_out_item))  out_ch ();
    lpl_chan_if #(.t_payload(t_cfg_write)) cfg_ch ();

    int send_idle_pct = 20;
    int recv_idle_pct = 54;
    int hold_request  = 0;
    bit fault_seen    = 1'b0;
    int fail_count;
    int pending;

    lookahead_peak_limiter dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    lookahead_peak_limiter_checker limiter_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_item    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_item   (out_ch.payload),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_write  (cfg_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: random throttling, or a long hold when one is requested
    initial begin : receive
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= STALL_LIMIT) begin
                $display("lookahead_peak_limiter verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic action, logic signed [23:0] sample, logic invalid);
        t_in_item item;
        item.action         = action;
        item.sample_in      = sample;
        item.sample_invalid = invalid;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= item;
        do @(posedge i_clk); while (!in_ch.ready);
        if (action == ACT_CLEAR) fault_seen = 1'b0;
        else if (invalid)        fault_seen = 1'b1;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    // wait for every predicted result, then let a clear pass or a late sample finish
    task automatic drain(int settle);
        do @(posedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [23:0] value);
        t_cfg_write w;
        w.index = idx;
        w.data  = value;
        @(negedge i_clk);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // unused upper data bits get random values
    task automatic configure(logic [23:0] thr, logic [22:0] ceil_v, logic [22:0] rel,
                             logic [7:0] win);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_CEILING, {1'($urandom_range(1)), ceil_v});
        write_reg(CFG_RELEASE, {1'($urandom_range(1)), rel});
        write_reg(CFG_WINDOW, {16'($urandom), win});
    endtask

    function automatic logic [23:0] pick_sample();
        int r;
        int m;
        r = $urandom_range(99);
        if (r < 35) return 24'($urandom);
        if (r < 60)      m = $urandom_range(0, 4194304);
        else if (r < 85) m = 8388608 - $urandom_range(0, 65536);
        else             m = $urandom_range(0, 2048);
        return 24'($urandom_range(1) ? -m : m);
    endfunction

    // mostly ordinary samples; faults are short-lived since a clear follows soon
    task automatic random_items(int count, int hold_at);
        int r;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_request = LONG_HOLD;
            r = $urandom_range(99);
            if (fault_seen && r < 30)
                send_item(ACT_CLEAR, 24'($urandom), 1'($urandom_range(1)));
            else if (r < 2)
                send_item(ACT_SAMPLE, pick_sample(), 1'b1);
            else if (r < 3)
                send_item(ACT_CLEAR, 24'($urandom), 1'($urandom_range(1)));
            else
                send_item(ACT_SAMPLE, pick_sample(), 1'b0);
        end
    endtask

    initial begin : stimulus
        logic [23:0] thr;
        logic [22:0] ceil_v;
        logic [22:0] rel;
        logic [7:0]  win;
        int          win_eff;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes and the fault/clear sequence at reset settings
        send_item(ACT_SAMPLE, 24'h7FFFFF, 1'b0);
        send_item(ACT_SAMPLE, 24'h800000, 1'b0);
        send_item(ACT_SAMPLE, 24'h000000, 1'b0);
        send_item(ACT_SAMPLE, 24'hFFFFFF, 1'b0);
        send_item(ACT_SAMPLE, 24'h000001, 1'b0);
        send_item(ACT_SAMPLE, 24'd7476394, 1'b0);
        send_item(ACT_SAMPLE, 24'd7476395, 1'b0);
        send_item(ACT_SAMPLE, 24'h400000, 1'b0);
        send_item(ACT_SAMPLE, 24'hC00000, 1'b0);
        send_item(ACT_SAMPLE, 24'h123456, 1'b1);
        send_item(ACT_SAMPLE, 24'h7FFFFF, 1'b0);
        send_item(ACT_CLEAR, 24'hABCDEF, 1'b1);
        send_item(ACT_SAMPLE, 24'h800000, 1'b0);
        stop_sending();
        drain(SETTLE_CYCLES);

        // one-sample window delays each extreme by one sample on its way to the output
        configure(THRESHOLD_RST, CEILING_RST, RELEASE_RST, 8'd1);
        send_item(ACT_SAMPLE, 24'h7FFFFF, 1'b0);
        send_item(ACT_SAMPLE, 24'h800000, 1'b0);
        send_item(ACT_SAMPLE, 24'hFFFFFF, 1'b0);
        send_item(ACT_SAMPLE, 24'h000001, 1'b0);
        send_item(ACT_SAMPLE, 24'h000000, 1'b0);
        send_item(ACT_SAMPLE, 24'h7FFFFF, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct = 54;
                recv_idle_pct = 20;
            end
            if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (p)
                0: begin
                    thr = 24'd8388608; ceil_v = 23'h7FFFFF; rel = 23'h7FFFFF; win = 8'd1;
                end
                1: begin
                    thr = 24'd0; ceil_v = 23'd0; rel = 23'd0; win = 8'd0;
                end
                2: begin
                    thr = 24'hFFFFFF; ceil_v = 23'h7FFFFF; rel = RELEASE_RST; win = 8'd128;
                end
                3: begin
                    thr = 24'd4194304; ceil_v = 23'd6000000; rel = 23'd0; win = 8'd255;
                end
                4: begin
                    // shrinking from the full ring leaves the write index past the end
                    thr    = 24'($urandom_range(0, 8388608));
                    ceil_v = 23'($urandom_range(3000000, 8388607));
                    rel    = 23'($urandom_range(8300000, 8388607));
                    win    = 8'd3;
                end
                default: begin
                    thr    = 24'($urandom_range(0, 8388608));
                    ceil_v = 23'($urandom_range(3000000, 8388607));
                    rel    = $urandom_range(1) ? 23'($urandom_range(8300000, 8388607))
                                               : 23'($urandom_range(0, 8388607));
                    win    = ($urandom_range(9) == 0) ? 8'($urandom_range(17, 255))
                                                      : 8'($urandom_range(1, 16));
                end
            endcase
            stop_sending();
            drain(SETTLE_CYCLES);
            configure(thr, ceil_v, rel, win);
            win_eff = (win == 0) ? 1 : ((win > MAX_LOOKAHEAD_DEF) ? MAX_LOOKAHEAD_DEF : win);
            random_items((win_eff >= 64) ? 60 : 115, (p == 5 || p == 9) ? 40 : -1);
        end

        stop_sending();
        drain(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("lookahead_peak_limiter verification clean");
        end else begin
            $display("lookahead_peak_limiter verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/lpl_pkg.sv
rtl/lpl_chan_if.sv
rtl/lpl_cfg_regs.sv
rtl/lpl_ring_mem.sv
rtl/lpl_div.sv
rtl/lookahead_peak_limiter.sv
tb/lookahead_peak_limiter_checker.sv
tb/lookahead_peak_limiter_test.sv
